>>> hdl/lcdw_pkg.sv
// lcdw_pkg: shared types, codes and constants for the LCD number display writer.
// Used by every module under hdl/; depends on nothing.
`default_nettype none

package lcdw_pkg;

  // request function codes
  typedef enum logic [2:0] {
    FUNC_CHAR = 3'd0,
    FUNC_UDEC = 3'd1,
    FUNC_SDEC = 3'd2,
    FUNC_HEX  = 3'd3,
    FUNC_INIT = 3'd4
  } func_t;

  // rows that place the cursor
  localparam logic [1:0] ROW_FIRST  = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;

  // LCD command bytes
  localparam logic [7:0] CMD_FUNCSET = 8'h38;
  localparam logic [7:0] CMD_DISPON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY   = 8'h06;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_ROW1    = 8'h80;
  localparam logic [7:0] CMD_ROW2    = 8'hC0;

  // character codes
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_HEX_A = 8'h37;  // 'A' - 10
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;

  localparam int         MAX_DIGITS = 5;
  localparam int         NUM_SLOTS  = 8;
  // n / 10 == (n * 52429) >> 19, exact for n < 81920
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [15:0] value;
    logic [2:0]  digit_count;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  // one candidate bus write of a request
  typedef struct packed {
    logic       en;
    logic       is_data;
    logic [7:0] bus_byte;
  } slot_t;

  // the full write list of one request, slot 0 goes out first
  typedef slot_t [NUM_SLOTS-1:0] job_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) begin
      return CHR_ZERO + ext;
    end else begin
      return CHR_HEX_A + ext;
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/lcdw_front.sv
// lcdw_front: accepts requests, converts decimal values one digit per cycle
// and builds the slot list handed to the queue. Depends on lcdw_pkg.
`default_nettype none

module lcdw_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  lcdw_pkg::in_item_t   in_item,
  input  wire                  q_full,
  output logic                 q_push,
  output lcdw_pkg::job_t       q_job
);

  logic        busy_r, busy_nxt;
  logic [2:0]  steps_r, steps_nxt;
  logic [2:0]  func_r;
  logic [5:0]  col_r;
  logic [1:0]  row_r;
  logic [7:0]  byte_r;
  logic        neg_r;
  logic [2:0]  cnt_r;
  logic [16:0] num_r;
  logic [3:0]  dig_r [lcdw_pkg::MAX_DIGITS];

  logic        accept, done, has_writes, release_job;
  logic [32:0] prod;
  logic [16:0] quo, quo10, rem_full;
  logic [2:0]  dig_idx;
  logic        cur_ok;
  logic [7:0]  row_base, cursor1, cursor2;
  logic [16:0] mag;
  logic        is_dec;

  // divide by ten through the reciprocal
  assign prod     = {16'b0, num_r} * {17'b0, lcdw_pkg::DIV10_MUL};
  assign quo      = 17'(prod >> lcdw_pkg::DIV10_SHIFT);
  assign quo10    = (quo << 3) + (quo << 1);
  assign rem_full = num_r - quo10;
  assign dig_idx  = 3'(lcdw_pkg::MAX_DIGITS) - steps_r;

  assign done        = busy_r && (steps_r == 3'd0);
  assign has_writes  = |{q_job[7].en, q_job[6].en, q_job[5].en, q_job[4].en,
                         q_job[3].en, q_job[2].en, q_job[1].en, q_job[0].en};
  assign release_job = done && (!has_writes || !q_full);
  assign q_push      = done && has_writes && !q_full;
  assign in_stall    = busy_r && !release_job;
  assign accept      = in_valid && !in_stall;

  assign is_dec = (in_item.func == lcdw_pkg::FUNC_UDEC) ||
                  (in_item.func == lcdw_pkg::FUNC_SDEC);
  assign mag    = (in_item.func == lcdw_pkg::FUNC_SDEC && in_item.value[15]) ?
                  17'h10000 - {1'b0, in_item.value} : {1'b0, in_item.value};

  always_comb begin
    busy_nxt  = busy_r;
    steps_nxt = steps_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      steps_nxt = is_dec ? 3'(lcdw_pkg::MAX_DIGITS) : 3'd0;
    end else if (release_job) begin
      busy_nxt = 1'b0;
    end else if (busy_r && steps_r != 3'd0) begin
      steps_nxt = steps_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      steps_r <= 3'd0;
    end else begin
      busy_r  <= busy_nxt;
      steps_r <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_item.func;
      col_r  <= in_item.column;
      row_r  <= in_item.row;
      byte_r <= in_item.value[7:0];
      neg_r  <= in_item.value[15];
      cnt_r  <= (in_item.digit_count > 3'(lcdw_pkg::MAX_DIGITS)) ?
                3'(lcdw_pkg::MAX_DIGITS) : in_item.digit_count;
      num_r  <= mag;
    end else if (busy_r && steps_r != 3'd0) begin
      dig_r[dig_idx] <= rem_full[3:0];
      num_r          <= quo;
    end
  end

  // cursor bytes; column zero wraps to 0xFF
  assign cur_ok   = (row_r == lcdw_pkg::ROW_FIRST) || (row_r == lcdw_pkg::ROW_SECOND);
  assign row_base = (row_r == lcdw_pkg::ROW_SECOND) ? lcdw_pkg::CMD_ROW2 : lcdw_pkg::CMD_ROW1;
  assign cursor1  = row_base | ({2'b00, col_r} - 8'd1);
  assign cursor2  = row_base | {2'b00, col_r};

  always_comb begin
    q_job = '0;
    case (func_r)
      lcdw_pkg::FUNC_CHAR: begin
        q_job[0] = '{en: cur_ok, is_data: 1'b0, bus_byte: cursor1};
        q_job[1] = '{en: 1'b1, is_data: 1'b1, bus_byte: byte_r};
      end
      lcdw_pkg::FUNC_UDEC, lcdw_pkg::FUNC_SDEC: begin
        q_job[0] = '{en: cur_ok, is_data: 1'b0, bus_byte: cursor1};
        if (func_r == lcdw_pkg::FUNC_SDEC) begin
          q_job[1] = '{en: 1'b1, is_data: 1'b1,
                       bus_byte: neg_r ? lcdw_pkg::CHR_MINUS : lcdw_pkg::CHR_PLUS};
          q_job[2] = '{en: cur_ok, is_data: 1'b0, bus_byte: cursor2};
        end
        // units digit in the last slot
        for (int i = 0; i < lcdw_pkg::MAX_DIGITS; i++) begin
          q_job[lcdw_pkg::NUM_SLOTS-1-i] = '{en: (3'(i) < cnt_r), is_data: 1'b1,
              bus_byte: lcdw_pkg::CHR_ZERO | {4'b0000, dig_r[i]}};
        end
      end
      lcdw_pkg::FUNC_HEX: begin
        q_job[0] = '{en: cur_ok, is_data: 1'b0, bus_byte: cursor1};
        q_job[1] = '{en: 1'b1, is_data: 1'b1, bus_byte: lcdw_pkg::hex_ascii(byte_r[7:4])};
        q_job[2] = '{en: 1'b1, is_data: 1'b1, bus_byte: lcdw_pkg::hex_ascii(byte_r[3:0])};
      end
      lcdw_pkg::FUNC_INIT: begin
        q_job[0] = '{en: 1'b1, is_data: 1'b0, bus_byte: lcdw_pkg::CMD_FUNCSET};
        q_job[1] = '{en: 1'b1, is_data: 1'b0, bus_byte: lcdw_pkg::CMD_DISPON};
        q_job[2] = '{en: 1'b1, is_data: 1'b0, bus_byte: lcdw_pkg::CMD_ENTRY};
        q_job[3] = '{en: 1'b1, is_data: 1'b0, bus_byte: lcdw_pkg::CMD_CLEAR};
      end
      default: begin
        q_job = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/lcdw_queue.sv
// lcdw_queue: small FIFO of write lists between front and back.
// Depends on lcdw_pkg.
`default_nettype none

module lcdw_queue #(
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  lcdw_pkg::job_t  push_job,
  output logic            full,
  input  wire             pop,
  output logic            head_valid,
  output lcdw_pkg::job_t  head_job
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lcdw_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lcdw_back.sv
// lcdw_back: walks the enabled slots of each write list, one bus write per
// cycle when not stalled, into a registered output stage. Depends on lcdw_pkg.
`default_nettype none

module lcdw_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  lcdw_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lcdw_pkg::out_item_t  out_item
);

  lcdw_pkg::job_t      cur_r;
  logic                cur_valid_r;
  logic                out_valid_r;
  lcdw_pkg::out_item_t out_r;

  logic [lcdw_pkg::NUM_SLOTS-1:0] en_mask, rest_mask;
  logic [2:0]                     sel;
  logic                           emit, is_last, finishing;

  always_comb begin
    for (int i = 0; i < lcdw_pkg::NUM_SLOTS; i++) begin
      en_mask[i] = cur_r[i].en;
    end
  end

  // lowest enabled slot goes next
  always_comb begin
    sel = 3'd0;
    for (int i = lcdw_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (en_mask[i]) begin
        sel = 3'(i);
      end
    end
  end

  always_comb begin
    rest_mask      = en_mask;
    rest_mask[sel] = 1'b0;
  end

  assign is_last   = (rest_mask == '0);
  assign emit      = cur_valid_r && (!out_valid_r || !out_stall);
  assign finishing = emit && is_last;
  assign q_pop     = q_valid && (!cur_valid_r || finishing);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
      end else if (finishing) begin
        cur_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end else if (emit) begin
      cur_r[sel].en <= 1'b0;
    end
    if (emit) begin
      out_r <= '{is_data: cur_r[sel].is_data, bus_byte: cur_r[sel].bus_byte,
                 last: is_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // a held list always has a write left
  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (en_mask != '0))
    else $error("held write list has no enabled slot");

  // the final write of a list comes from its single remaining slot
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    finishing |-> ($countones(en_mask) == 1))
    else $error("list finished with slots left");

  // an idle sequencer picks up a waiting list at once
  a_pickup: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !cur_valid_r) |=> cur_valid_r)
    else $error("waiting list not taken");

endmodule

`default_nettype wire

>>> hdl/lcd_number_display_writer_core.sv
// lcd_number_display_writer_core: top level of the character-LCD write sequencer.
// Depends on lcdw_pkg, lcdw_front, lcdw_queue and lcdw_back.
//
// Usage:
//   in_valid/in_stall/in_item carry display requests (func, column, row,
//   value, digit_count). A transaction completes on a rising edge with
//   in_valid high and in_stall low.
//   out_valid/out_stall/out_item carry LCD bus writes (is_data, bus_byte,
//   last); last marks the final write of a request. Requests that cause no
//   write (unused func codes) produce no output transaction.
// Timing:
//   char, hex and init requests go straight to the hand-off in the front;
//   decimal requests first take five digit steps through the divide-by-ten
//   multiplier. The back emits one write per cycle while out_stall is low,
//   and the front can convert the next request while the back writes the
//   one before. A first write passes the front, the queue, the back's list
//   register and the output register in that order.
// Reset: rst_n low clears the front, the queue and the output stage; no
//   memory to sweep, requests are taken the cycle after reset ends.
// Stall: out_stall holds the output register; the back stops, the queue fills,
//   and in_stall rises once the front cannot hand off (or while it converts).
`default_nettype none

module lcd_number_display_writer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  lcdw_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lcdw_pkg::out_item_t  out_item
);

  logic           q_push, q_full, q_pop, q_valid;
  lcdw_pkg::job_t push_job, head_job;

  // front: accept, digit conversion, slot list build
  lcdw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // decouples conversion from bus sequencing
  lcdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // back: one bus write per cycle into the output register while not stalled
  lcdw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> dv/lcdw_write_checker.sv
// lcdw_write_checker: watches both channels of the LCD write sequencer, predicts the
// bus writes of every accepted request and compares them with the writes that come out.
// Depends on lcdw_pkg for the request and write types and the LCD byte codes.
`timescale 1ns / 1ps

module lcdw_write_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  lcdw_pkg::in_item_t  in_item,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  lcdw_pkg::out_item_t out_item,
  output int                  check_errors,
  output int                  writes_pending
);
  import lcdw_pkg::*;

  out_item_t  expected_writes[$];

  // scratch list of the writes of one request
  logic       run_data [NUM_SLOTS];
  logic [7:0] run_byte [NUM_SLOTS];
  int         run_len;

  out_item_t  want;

  task push_write(input logic is_data, input logic [7:0] bus_byte);
    if (run_len < NUM_SLOTS) begin
      run_data[run_len] = is_data;
      run_byte[run_len] = bus_byte;
      run_len++;
    end
  endtask

  // column counts from 1; column 0 wraps to position 0xFF
  task push_cursor(input int col, input logic [1:0] row);
    logic [7:0] pos;
    pos = 8'(col - 1);
    if (row == ROW_FIRST) begin
      push_write(1'b0, CMD_ROW1 | pos);
    end else if (row == ROW_SECOND) begin
      push_write(1'b0, CMD_ROW2 | pos);
    end
  endtask

  task push_digits(input int number, input logic [2:0] count);
    int         ndig;
    int         scale;
    logic [7:0] dig;
    ndig = (int'(count) > MAX_DIGITS) ? MAX_DIGITS : int'(count);
    for (int k = ndig; k > 0; k--) begin
      scale = 1;
      repeat (k - 1) scale = scale * 10;
      dig = 8'((number / scale) % 10);
      push_write(1'b1, CHR_ZERO + dig);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    return (nib < 4'd10) ? CHR_ZERO + wide : CHR_HEX_A + wide;
  endfunction

  task predict_bus_writes(input in_item_t req);
    int        col;
    int        mag;
    out_item_t w;
    col = int'(req.column);
    run_len = 0;
    case (req.func)
      FUNC_CHAR: begin
        push_cursor(col, req.row);
        push_write(1'b1, req.value[7:0]);
      end
      FUNC_UDEC: begin
        push_cursor(col, req.row);
        push_digits(int'(req.value), req.digit_count);
      end
      FUNC_SDEC: begin
        push_cursor(col, req.row);
        if (!req.value[15]) begin
          push_write(1'b1, CHR_PLUS);
          mag = int'(req.value);
        end else begin
          push_write(1'b1, CHR_MINUS);
          mag = 65536 - int'(req.value);   // -32768 gives 32768
        end
        push_cursor(col + 1, req.row);
        push_digits(mag, req.digit_count);
      end
      FUNC_HEX: begin
        push_cursor(col, req.row);
        push_write(1'b1, hex_char(req.value[7:4]));
        push_write(1'b1, hex_char(req.value[3:0]));
      end
      FUNC_INIT: begin
        push_write(1'b0, CMD_FUNCSET);
        push_write(1'b0, CMD_DISPON);
        push_write(1'b0, CMD_ENTRY);
        push_write(1'b0, CMD_CLEAR);
      end
      default: ;  // unused codes cause no writes
    endcase
    for (int k = 0; k < run_len; k++) begin
      w.is_data  = run_data[k];
      w.bus_byte = run_byte[k];
      w.last     = (k == run_len - 1);
      expected_writes.push_back(w);
    end
  endtask

  initial begin
    check_errors   = 0;
    writes_pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_bus_writes(in_item);
      end
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          if (check_errors < 10) begin
            $display("lcdw_write_checker: unexpected write is_data=%0b byte=%02h last=%0b",
                     out_item.is_data, out_item.bus_byte, out_item.last);
          end
          check_errors++;
        end else begin
          want = expected_writes.pop_front();
          if (out_item.is_data !== want.is_data || out_item.bus_byte !== want.bus_byte ||
              out_item.last !== want.last) begin
            if (check_errors < 10) begin
              $display("lcdw_write_checker: expected %0b/%02h/%0b actual %0b/%02h/%0b",
                       want.is_data, want.bus_byte, want.last,
                       out_item.is_data, out_item.bus_byte, out_item.last);
            end
            check_errors++;
          end
        end
      end
    end
    writes_pending <= expected_writes.size();
  end

endmodule

>>> dv/tb_top.sv
// tb_top: stimulus and verdict for lcd_number_display_writer_core.
// Depends on lcdw_pkg, the core under hdl/ and dv/lcdw_write_checker.sv.
`timescale 1ns / 1ps

module tb_top;
  import lcdw_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int        check_errors;
  int        writes_pending;

  // idle odds in percent, changed per phase
  int        send_idle_pct;
  int        stall_pct;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lcd_number_display_writer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  lcdw_write_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .check_errors   (check_errors),
    .writes_pending (writes_pending)
  );

  // Receiver: stall is an independent coin toss every cycle.
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic in_item_t mk_req(input logic [2:0] func, input logic [5:0] column,
                                      input logic [1:0] row, input logic [15:0] value,
                                      input logic [2:0] digit_count);
    in_item_t r;
    r.func        = func;
    r.column      = column;
    r.row         = row;
    r.value       = value;
    r.digit_count = digit_count;
    return r;
  endfunction

  // Mostly well-formed requests: valid func, on-screen column, sane digit count.
  // A small share goes off the edges (unused func, column 0 or past 40, count 6/7).
  function automatic in_item_t random_request();
    in_item_t r;
    r.func   = 3'(($urandom_range(99) < 92) ? $urandom_range(4) : $urandom_range(7, 5));
    r.column = 6'(($urandom_range(99) < 85) ? $urandom_range(40, 1) : $urandom_range(63));
    r.row    = 2'($urandom_range(3));
    case ($urandom_range(9))
      0:       r.value = 16'h0000;
      1:       r.value = 16'hFFFF;
      2:       r.value = 16'h8000;
      3:       r.value = 16'h7FFF;
      default: r.value = 16'($urandom);
    endcase
    r.digit_count = 3'(($urandom_range(99) < 85) ? $urandom_range(5) : $urandom_range(7, 6));
    return r;
  endfunction

  // One transaction on the request channel, then a random idle gap.
  // Valid stays high straight into the next request when no gap is drawn.
  task automatic send_request(input in_item_t req);
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      in_item  <= random_request();  // junk payload while idle
      @(posedge clk);
    end
  endtask

  // Random part of one idling phase; every 40 items ends in a burst with no idling.
  task automatic run_phase(input int n, input int send_pct, input int rcv_pct);
    for (int i = 0; i < n; i++) begin
      if ((i % 40) >= 32) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else begin
        send_idle_pct = send_pct;
        stall_pct     = rcv_pct;
      end
      send_request(random_request());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every function, field extremes and the corner cases.
    send_request(mk_req(FUNC_INIT, 6'd1,  2'd0, 16'h0000, 3'd0));
    send_request(mk_req(FUNC_CHAR, 6'd1,  ROW_FIRST,  16'h0041, 3'd0));
    send_request(mk_req(FUNC_CHAR, 6'd40, ROW_SECOND, 16'hFFFF, 3'd7));
    send_request(mk_req(FUNC_CHAR, 6'd5,  2'd0, 16'h1230, 3'd0));      // no cursor
    send_request(mk_req(FUNC_CHAR, 6'd5,  2'd3, 16'h00FF, 3'd0));      // no cursor
    send_request(mk_req(FUNC_UDEC, 6'd1,  ROW_FIRST,  16'hFFFF, 3'd5));
    send_request(mk_req(FUNC_UDEC, 6'd40, ROW_SECOND, 16'h0000, 3'd5));
    send_request(mk_req(FUNC_UDEC, 6'd7,  ROW_FIRST,  16'd1234, 3'd0)); // cursor only
    send_request(mk_req(FUNC_UDEC, 6'd7,  2'd0, 16'd1234, 3'd0));      // empty run
    send_request(mk_req(FUNC_UDEC, 6'd3,  ROW_SECOND, 16'd54321, 3'd7)); // count saturates
    send_request(mk_req(FUNC_UDEC, 6'd3,  2'd3, 16'd987, 3'd6));
    send_request(mk_req(FUNC_UDEC, 6'd9,  ROW_FIRST,  16'd98765, 3'd2));
    send_request(mk_req(FUNC_SDEC, 6'd1,  ROW_FIRST,  16'h7FFF, 3'd5));
    send_request(mk_req(FUNC_SDEC, 6'd2,  ROW_SECOND, 16'h8000, 3'd5)); // most negative
    send_request(mk_req(FUNC_SDEC, 6'd10, ROW_SECOND, 16'hFFFF, 3'd1));
    send_request(mk_req(FUNC_SDEC, 6'd63, ROW_FIRST,  16'h0000, 3'd7));
    send_request(mk_req(FUNC_SDEC, 6'd4,  2'd0, 16'hC000, 3'd0));
    send_request(mk_req(FUNC_HEX,  6'd1,  ROW_FIRST,  16'h00AB, 3'd0));
    send_request(mk_req(FUNC_HEX,  6'd20, ROW_SECOND, 16'hFF09, 3'd0));
    send_request(mk_req(FUNC_HEX,  6'd20, 2'd3, 16'h12F0, 3'd0));
    send_request(mk_req(FUNC_CHAR, 6'd0,  ROW_FIRST,  16'h0030, 3'd0)); // column zero wraps
    send_request(mk_req(FUNC_HEX,  6'd0,  ROW_SECOND, 16'h005A, 3'd0));
    send_request(mk_req(3'd5, 6'd63, ROW_FIRST,  16'hFFFF, 3'd7));      // unused codes
    send_request(mk_req(3'd6, 6'd1,  ROW_SECOND, 16'h0000, 3'd0));
    send_request(mk_req(3'd7, 6'd42, 2'd3, 16'h5555, 3'd5));

    // Random phases: no idling, sender idle, receiver stalling, both.
    run_phase(75, 0, 0);
    run_phase(75, 77, 0);
    run_phase(75, 0, 77);
    run_phase(75, 14, 14);

    in_valid      <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    // drain: decimal requests run their digit steps before their first write
    repeat (40) @(posedge clk);

    if (check_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> lcd_number_display_writer_core.f
hdl/lcdw_pkg.sv
hdl/lcdw_front.sv
hdl/lcdw_queue.sv
hdl/lcdw_back.sv
hdl/lcd_number_display_writer_core.sv
dv/lcdw_write_checker.sv
dv/tb_top.sv
